/* hw/rtl/wso_pkg.sv */
// shared types, constants and codes of the wheel speed odometer
package wso_pkg;

  localparam int TIME_BITS  = 40;
  localparam int DIST_BITS  = 32;
  localparam int SPEED_BITS = 22;
  localparam int FACT_BITS  = 12;
  localparam int NUM_BITS   = DIST_BITS + FACT_BITS;
  localparam int DSH_BITS   = TIME_BITS + SPEED_BITS;
  localparam int CNT_BITS   = $clog2(SPEED_BITS);

  localparam logic [FACT_BITS-1:0]  CENTI_KMH_FACTOR = FACT_BITS'(3600);
  localparam logic [SPEED_BITS-1:0] SPEED_MAX        = '1;
  localparam logic [TIME_BITS-1:0]  TIME_MAX         = '1;
  localparam logic [DIST_BITS-1:0]  DIST_MAX         = '1;

  typedef logic [TIME_BITS-1:0]  time_t;
  typedef logic [DIST_BITS-1:0]  dist_t;
  typedef logic [SPEED_BITS-1:0] speed_t;

  // input commands
  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_PULSE  = 2'd1;
  localparam logic [1:0] CMD_BUTTON = 2'd2;

  // display modes
  localparam logic [1:0] MODE_SPEED = 2'd0;
  localparam logic [1:0] MODE_DIST  = 2'd1;
  localparam logic [1:0] MODE_AVG   = 2'd2;

  // register indexes
  localparam logic [2:0] REG_DIST_PER_REV = 3'd0;
  localparam logic [2:0] REG_PULSE_LOCK   = 3'd1;
  localparam logic [2:0] REG_REFRESH      = 3'd2;
  localparam logic [2:0] REG_LONG_PRESS   = 3'd3;
  localparam logic [2:0] REG_BTN_LOCK     = 3'd4;
  localparam logic [2:0] REG_ACTIVE_LEVEL = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SPD_START,
    ST_SPD_WAIT,
    ST_AVG_START,
    ST_AVG_WAIT,
    ST_FIN
  } seq_state_t;

  typedef enum logic [2:0] {
    DV_IDLE,
    DV_MUL,
    DV_CHK,
    DV_ITER,
    DV_DONE
  } div_state_t;

  typedef struct packed {
    logic  start;
    dist_t cm;
    time_t den;
  } div_req_t;

  typedef struct packed {
    logic   done;
    speed_t quot;
  } div_rsp_t;

  typedef struct packed {
    logic in_ready;
    logic div_start;
    logic sel_avg;
    logic ld_exec;
    logic ld_speed;
    logic ld_avg;
    logic ld_out;
  } seq_ctl_t;

endpackage

/* hw/rtl/wso_if.sv */
// valid/ready channels for input items and result items
interface wso_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic       button_level;

  modport source (output valid, output command, output button_level, input ready);
  modport sink   (input valid, input command, input button_level, output ready);
endinterface

interface wso_out_if;
  logic        valid;
  logic        ready;
  logic [21:0] speed_centi_kmh;
  logic [31:0] distance_cm;
  logic [21:0] avg_centi_kmh;
  logic [39:0] trip_time_ms;
  logic [1:0]  display_mode;

  modport source (output valid, output speed_centi_kmh, output distance_cm,
                  output avg_centi_kmh, output trip_time_ms, output display_mode,
                  input ready);
  modport sink   (input valid, input speed_centi_kmh, input distance_cm,
                  input avg_centi_kmh, input trip_time_ms, input display_mode,
                  output ready);
endinterface

/* hw/rtl/wso_div.sv */
// serial rate unit: floor(dist * 3600 / den), saturating, one quotient bit per cycle
module wso_div (
  input  logic              clk,
  input  logic              rst_n,
  input  wso_pkg::div_req_t req,
  output wso_pkg::div_rsp_t rsp
);
  import wso_pkg::*;

  div_state_t          st_r, st_nxt;
  dist_t               dist_r;
  time_t               den_r;
  logic [NUM_BITS-1:0] num_r;
  logic [NUM_BITS-1:0] rem_r;
  logic [DSH_BITS-1:0] dsh_r;
  speed_t              quot_r;
  logic [CNT_BITS-1:0] cnt_r;

  logic                over;
  logic                fits;

  // quotient would not fit in the speed width
  assign over = {{(DSH_BITS-NUM_BITS){1'b0}}, num_r} >= {den_r, {SPEED_BITS{1'b0}}};
  assign fits = {{(DSH_BITS-NUM_BITS){1'b0}}, rem_r} >= dsh_r;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      DV_IDLE: if (req.start) st_nxt = DV_MUL;
      DV_MUL:  st_nxt = DV_CHK;
      DV_CHK: begin
        if (dist_r == '0 || den_r == '0 || over) st_nxt = DV_DONE;
        else st_nxt = DV_ITER;
      end
      DV_ITER: if (cnt_r == '0) st_nxt = DV_DONE;
      DV_DONE: st_nxt = DV_IDLE;
      default: st_nxt = DV_IDLE;
    endcase
  end

  always_comb begin
    rsp.done = (st_r == DV_DONE);
    rsp.quot = quot_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= DV_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      DV_IDLE: begin
        if (req.start) begin
          dist_r <= req.cm;
          den_r  <= req.den;
        end
      end
      DV_MUL: begin
        num_r <= dist_r * CENTI_KMH_FACTOR;
      end
      DV_CHK: begin
        rem_r  <= num_r;
        dsh_r  <= {1'b0, den_r, {(SPEED_BITS-1){1'b0}}};
        cnt_r  <= CNT_BITS'(SPEED_BITS - 1);
        if (dist_r == '0) quot_r <= '0;
        else if (den_r == '0 || over) quot_r <= SPEED_MAX;
        else quot_r <= '0;
      end
      DV_ITER: begin
        if (fits) rem_r <= rem_r - dsh_r[NUM_BITS-1:0];
        quot_r <= {quot_r[SPEED_BITS-2:0], fits};
        dsh_r  <= dsh_r >> 1;
        cnt_r  <= cnt_r - 1'b1;
      end
      DV_DONE: begin
      end
      default: begin
      end
    endcase
  end

endmodule

/* hw/rtl/wheel_speed_odometer.sv */
// top level of the wheel speed odometer: sequencer, trip state, registers, output stage
//
// Each input beat is one event: a millisecond tick, a wheel pulse or a button
// level change. The block takes one beat at a time and delivers one result beat
// per input beat with speed, trip distance, average speed, trip time and the
// display mode as they stand after the event. Each item passes the exec state,
// the average division and the finish state; a wheel pulse or a speed refresh
// adds a speed division first, and zero and saturating rates end early. Both
// divisions use the single serial divider, which yields one quotient bit per
// cycle over the 22-bit speed range and is used once for the speed and once for
// the average. A finished result waits in the output register, so the next beat
// is taken while it waits; only a second finished result stalls on it.
// Configuration is written over the APB port with registers at byte addresses
// 0, 4, ... 20; write only while the block is idle.
module wheel_speed_odometer (
  input  logic        clk,
  input  logic        rst_n,
  wso_in_if.sink      in_ch,
  wso_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import wso_pkg::*;

  // configuration registers
  logic [9:0]  dpr_r;
  logic [9:0]  pulse_lock_r;
  logic [15:0] refresh_per_r;
  logic [15:0] long_press_r;
  logic [9:0]  btn_lock_r;
  logic        active_lvl_r;

  // trip state
  time_t       now_r, now_nxt;
  time_t       last_pulse_r, last_pulse_nxt;
  logic        pulse_seen_r, pulse_seen_nxt;
  speed_t      speed_r;
  dist_t       distance_r, distance_nxt;
  time_t       trip_r, trip_nxt;
  logic [1:0]  mode_r, mode_nxt;
  logic        held_r, held_nxt;
  time_t       press_start_r, press_start_nxt;
  time_t       last_edge_r, last_edge_nxt;
  logic [15:0] refresh_r, refresh_nxt;
  speed_t      avg_r;

  // captured beat and pending speed work
  logic [1:0]  cmd_r;
  logic        lvl_r;
  time_t       el_r, el_nxt;
  logic        spd_need;

  // output stage
  logic        out_valid_r, out_valid_nxt;

  seq_state_t  st_r, st_nxt;
  seq_ctl_t    ctl;
  div_req_t    div_req;
  div_rsp_t    div_rsp;

  // event arithmetic
  time_t       now_inc;
  time_t       el_tick;
  time_t       el_now;
  time_t       edge_el;
  time_t       press_el;
  logic [15:0] refresh_inc;
  logic [DIST_BITS:0] dist_sum;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // register read back
  always_comb begin
    prdata = '0;
    unique case (paddr[4:2])
      REG_DIST_PER_REV: prdata = {22'b0, dpr_r};
      REG_PULSE_LOCK:   prdata = {22'b0, pulse_lock_r};
      REG_REFRESH:      prdata = {16'b0, refresh_per_r};
      REG_LONG_PRESS:   prdata = {16'b0, long_press_r};
      REG_BTN_LOCK:     prdata = {22'b0, btn_lock_r};
      REG_ACTIVE_LEVEL: prdata = {31'b0, active_lvl_r};
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dpr_r         <= 10'd200;
      pulse_lock_r  <= 10'd200;
      refresh_per_r <= 16'd1000;
      long_press_r  <= 16'd1000;
      btn_lock_r    <= 10'd50;
      active_lvl_r  <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_DIST_PER_REV: dpr_r         <= pwdata[9:0];
        REG_PULSE_LOCK:   pulse_lock_r  <= pwdata[9:0];
        REG_REFRESH:      refresh_per_r <= pwdata[15:0];
        REG_LONG_PRESS:   long_press_r  <= pwdata[15:0];
        REG_BTN_LOCK:     btn_lock_r    <= pwdata[9:0];
        REG_ACTIVE_LEVEL: active_lvl_r  <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  // sequencer: next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE:      if (in_ch.valid) st_nxt = ST_EXEC;
      ST_EXEC:      st_nxt = spd_need ? ST_SPD_START : ST_AVG_START;
      ST_SPD_START: st_nxt = ST_SPD_WAIT;
      ST_SPD_WAIT:  if (div_rsp.done) st_nxt = ST_AVG_START;
      ST_AVG_START: st_nxt = ST_AVG_WAIT;
      ST_AVG_WAIT:  if (div_rsp.done) st_nxt = ST_FIN;
      ST_FIN:       if (!out_valid_r || out_ch.ready) st_nxt = ST_IDLE;
      default:      st_nxt = ST_IDLE;
    endcase
  end

  // sequencer: outputs
  always_comb begin
    ctl = '0;
    unique case (st_r)
      ST_IDLE:      ctl.in_ready = 1'b1;
      ST_EXEC:      ctl.ld_exec = 1'b1;
      ST_SPD_START: ctl.div_start = 1'b1;
      ST_SPD_WAIT:  ctl.ld_speed = div_rsp.done;
      ST_AVG_START: begin
        ctl.div_start = 1'b1;
        ctl.sel_avg   = 1'b1;
      end
      ST_AVG_WAIT:  ctl.ld_avg = div_rsp.done;
      ST_FIN:       ctl.ld_out = !out_valid_r || out_ch.ready;
      default: begin
      end
    endcase
  end

  assign in_ch.ready = ctl.in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  // shared rate unit: speed from revolution length and interval, or trip average
  always_comb begin
    div_req.start = ctl.div_start;
    div_req.cm    = ctl.sel_avg ? distance_r : {{(DIST_BITS-10){1'b0}}, dpr_r};
    div_req.den   = ctl.sel_avg ? trip_r : el_r;
  end

  wso_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign now_inc     = now_r + 1'b1;
  assign el_tick     = now_inc - last_pulse_r;
  assign el_now      = now_r - last_pulse_r;
  assign edge_el     = now_r - last_edge_r;
  assign press_el    = now_r - press_start_r;
  assign refresh_inc = refresh_r + 16'd1;
  assign dist_sum    = {1'b0, distance_r} + {{(DIST_BITS-9){1'b0}}, dpr_r};

  // event handling, applied in the exec state
  always_comb begin
    now_nxt         = now_r;
    last_pulse_nxt  = last_pulse_r;
    pulse_seen_nxt  = pulse_seen_r;
    distance_nxt    = distance_r;
    trip_nxt        = trip_r;
    mode_nxt        = mode_r;
    held_nxt        = held_r;
    press_start_nxt = press_start_r;
    last_edge_nxt   = last_edge_r;
    refresh_nxt     = refresh_r;
    el_nxt          = el_r;
    spd_need        = 1'b0;
    priority if (cmd_r == CMD_TICK) begin
      now_nxt = now_inc;
      if (trip_r != TIME_MAX) trip_nxt = trip_r + 1'b1;
      refresh_nxt = refresh_inc;
      // refresh period reached: decay speed from time since last pulse
      if (refresh_inc >= refresh_per_r) begin
        refresh_nxt = '0;
        el_nxt      = el_tick;
        spd_need    = pulse_seen_r && (el_tick >= {{(TIME_BITS-16){1'b0}}, refresh_per_r})
                      && (el_tick != '0);
      end
    end else if (cmd_r == CMD_PULSE) begin
      // pulse outside the lockout counts as one revolution
      if (el_now > {{(TIME_BITS-10){1'b0}}, pulse_lock_r}) begin
        el_nxt         = el_now;
        spd_need       = 1'b1;
        distance_nxt   = dist_sum[DIST_BITS] ? DIST_MAX : dist_sum[DIST_BITS-1:0];
        pulse_seen_nxt = 1'b1;
        last_pulse_nxt = now_r;
      end
    end else if (cmd_r == CMD_BUTTON) begin
      // debounce: any edge outside the lockout restarts it
      if (edge_el >= {{(TIME_BITS-10){1'b0}}, btn_lock_r}) begin
        last_edge_nxt = now_r;
        if (lvl_r == active_lvl_r) begin
          if (!held_r) begin
            held_nxt        = 1'b1;
            press_start_nxt = now_r;
          end
        end else if (held_r) begin
          held_nxt = 1'b0;
          if (press_el >= {{(TIME_BITS-16){1'b0}}, long_press_r}) begin
            // long press clears the trip
            distance_nxt = '0;
            trip_nxt     = '0;
          end else begin
            mode_nxt = (mode_r == MODE_AVG) ? MODE_SPEED : mode_r + 1'b1;
          end
        end
      end
    end else begin
      // unused command code leaves the state alone
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r         <= '0;
      last_pulse_r  <= '0;
      pulse_seen_r  <= 1'b0;
      speed_r       <= '0;
      distance_r    <= '0;
      trip_r        <= '0;
      mode_r        <= MODE_SPEED;
      held_r        <= 1'b0;
      press_start_r <= '0;
      last_edge_r   <= '0;
      refresh_r     <= '0;
    end else begin
      if (ctl.ld_exec) begin
        now_r         <= now_nxt;
        last_pulse_r  <= last_pulse_nxt;
        pulse_seen_r  <= pulse_seen_nxt;
        distance_r    <= distance_nxt;
        trip_r        <= trip_nxt;
        mode_r        <= mode_nxt;
        held_r        <= held_nxt;
        press_start_r <= press_start_nxt;
        last_edge_r   <= last_edge_nxt;
        refresh_r     <= refresh_nxt;
      end
      if (ctl.ld_speed) speed_r <= div_rsp.quot;
    end
  end

  // beat capture and rate operands
  always_ff @(posedge clk) begin
    if (in_ch.valid && ctl.in_ready) begin
      cmd_r <= in_ch.command;
      lvl_r <= in_ch.button_level;
    end
    if (ctl.ld_exec) el_r <= el_nxt;
    if (ctl.ld_avg) avg_r <= div_rsp.quot;
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.ld_out) out_valid_nxt = 1'b1;
    else if (out_ch.ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_out) begin
      out_ch.speed_centi_kmh <= speed_r;
      out_ch.distance_cm     <= distance_r;
      // zero distance shows zero average whatever the trip time
      out_ch.avg_centi_kmh   <= (distance_r == '0) ? '0 : avg_r;
      out_ch.trip_time_ms    <= trip_r;
      out_ch.display_mode    <= mode_r;
    end
  end

  assign out_ch.valid = out_valid_r;

endmodule
